// ===== src/swsyn_pkg.sv =====
// Shared constants for the sweep waveform synthesiser: register indexes,
// wave codes, reset values and the sine ROM build constants. No dependencies.
`default_nettype none

package swsyn_pkg;

    // Default values of the top-level parameters
    localparam int DEF_SINE_DEPTH  = 1024;
    localparam int DEF_PHASE_BITS  = 32;
    localparam int DEF_SAMPLE_BITS = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_EN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_TYPE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PH  = 3'd5;

    // Wave type codes; the codes above square are silent
    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_SAW      = 3'd1;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [2:0] WAVE_SQUARE   = 3'd3;

    // Register reset values
    localparam logic [31:0] RST_BASE_INC = 32'd39370534;
    localparam logic [31:0] UNITY_Q30    = 32'd1073741824;
    localparam logic [15:0] RST_DUTY     = 16'd32768;
    localparam logic [31:0] RST_START_PH = 32'd0;

    // Waveform values are Q16 and span 18 signed bits; sine entries are 0..65536
    localparam int WAVE_W = 18;
    localparam int SIN_W  = 17;

    // Sine ROM build: pi/2 in Q30 and the Taylor divisors (2n)(2n+1), n = 1..12
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int          TAYLOR_TERMS = 12;
    localparam logic [63:0] SINE_DIV [TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

endpackage

`default_nettype wire

// ===== src/sweep_waveform_synth.sv =====
// Sweep waveform synthesiser: DDS oscillator with exponential frequency sweep.
// Pipeline: three register stages (stage 1, stage 2 with the ROM read, stage 3); an
// accepted request passes through them in that order to the output.
// Throughput: one request per cycle; the three stages stall only from the output back.
// Reset (synchronous, active low): registers to defaults, phase to the start phase
// default, increment to the base increment default, pipeline emptied, no request taken.
// Depends on swsyn_pkg and swsyn_sine_rom.
`default_nettype none

module sweep_waveform_synth #(
    parameter int SINE_TABLE_DEPTH = swsyn_pkg::DEF_SINE_DEPTH,
    parameter int PHASE_BITS       = swsyn_pkg::DEF_PHASE_BITS,
    parameter int SAMPLE_BITS      = swsyn_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,

    // configuration write channel
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [swsyn_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [31:0]                           i_cfg_data,

    // tick requests
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    input  wire logic [15:0]                           i_s_axis_tdata,  // [15:0] amplitude
    input  wire logic                                  i_s_axis_tuser,  // [0] restart

    // samples
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]           o_m_axis_tdata   // sample, zero padded
);
    import swsyn_pkg::*;

    localparam int AW    = $clog2(SINE_TABLE_DEPTH + 1);  // sine ROM address bits
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SHIFT = 32 - SAMPLE_BITS;               // Q16 x Q15 down to sample
    localparam int PW    = WAVE_W + 17;                    // wave x amplitude
    localparam int RW    = PW + 1;                         // after rounding bias

    localparam logic signed [RW-1:0] RND_BIAS = RW'(64'd1 << (SHIFT - 1));
    localparam logic signed [RW-1:0] SMP_HI   = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RW-1:0] SMP_LO   = RW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // ------------------------------------------------------------------
    // Configuration registers; ready outside reset, writes are registered
    // ------------------------------------------------------------------
    logic [31:0] r_base;
    logic [31:0] r_factor;
    logic        r_sweep_en;
    logic [2:0]  r_wave;
    logic [15:0] r_duty;
    logic [31:0] r_start;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= RST_BASE_INC;
            r_factor   <= UNITY_Q30;
            r_sweep_en <= 1'b0;
            r_wave     <= WAVE_SINE;
            r_duty     <= RST_DUTY;
            r_start    <= RST_START_PH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BASE_INC:  r_base     <= i_cfg_data;
                CFG_FACTOR:    r_factor   <= i_cfg_data;
                CFG_SWEEP_EN:  r_sweep_en <= i_cfg_data[0];
                CFG_WAVE_TYPE: r_wave     <= i_cfg_data[2:0];
                CFG_DUTY:      r_duty     <= i_cfg_data[15:0];
                CFG_START_PH:  r_start    <= i_cfg_data;
                default: ;     // unknown index: dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow: each stage moves when the next is empty or moving
    // ------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_s3_v;
    logic en1, en2, en3;
    logic s_acc;

    assign en3             = !r_s3_v || i_m_axis_tready;
    assign en2             = !r_s2_v || en3;
    assign en1             = !r_s1_v || en2;
    assign o_s_axis_tready = en1 && i_rst_n;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // ------------------------------------------------------------------
    // Oscillator state: restart mux, phase add, sweep multiply
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0]    r_phase;
    logic [PHASE_BITS-1:0]    r_inc;
    logic [PHASE_BITS-1:0]    base_ph;
    logic [PHASE_BITS-1:0]    start_ph;
    logic [PHASE_BITS-1:0]    p0;
    logic [PHASE_BITS-1:0]    inc0;
    logic [PHASE_BITS-1:0]    n_phase;
    logic [PHASE_BITS-1:0]    n_inc;
    logic [PHASE_BITS+31:0]   sweep_prod;
    logic [PHASE_BITS+1:0]    sweep_q;
    logic [PHASE_BITS+31:0]   ph_ext;
    logic [31:0]              u0;

    always_comb begin
        base_ph    = PHASE_BITS'(r_base);
        start_ph   = PHASE_BITS'(r_start);
        p0         = i_s_axis_tuser ? start_ph : r_phase;
        inc0       = i_s_axis_tuser ? base_ph  : r_inc;
        n_phase    = p0 + inc0;
        // Q2.30 factor: keep product >> 30, clamp at all ones
        sweep_prod = (PHASE_BITS+32)'(inc0) * (PHASE_BITS+32)'(r_factor);
        sweep_q    = sweep_prod[PHASE_BITS+31:30];
        if (r_sweep_en && (r_factor != UNITY_Q30)) begin
            n_inc = (|sweep_q[PHASE_BITS+1:PHASE_BITS]) ? '1 : sweep_q[PHASE_BITS-1:0];
        end else begin
            n_inc = inc0;
        end
        // top 32 bits of the phase as a cycle fraction
        ph_ext = {p0, 32'd0};
        u0     = ph_ext[PHASE_BITS+31 -: 32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_BITS'(RST_START_PH);
            r_inc   <= PHASE_BITS'(RST_BASE_INC);
        end else if (s_acc) begin
            r_phase <= n_phase;
            r_inc   <= n_inc;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: phase fraction; sine address and the computed waves
    // ------------------------------------------------------------------
    logic [31:0]            r_s1_u;
    logic [15:0]            r_s1_amp;
    logic [30+AW-1:0]       idx_prod;
    logic [AW-1:0]          idx_i;
    logic [AW-1:0]          rom_addr;
    logic [WAVE_W-1:0]      w_calc;
    logic [WAVE_W-1:0]      saw_v;
    logic [WAVE_W-1:0]      tri_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en1) begin
            r_s1_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_u   <= u0;
            r_s1_amp <= i_s_axis_tdata;
        end
    end

    always_comb begin
        // quarter-wave index, mirrored in the odd quadrants
        idx_prod = (30+AW)'(r_s1_u[29:0]) * (30+AW)'(SINE_TABLE_DEPTH);
        idx_i    = idx_prod[30+AW-1:30];
        rom_addr = r_s1_u[30] ? (AW'(SINE_TABLE_DEPTH) - idx_i) : idx_i;

        // all in 18-bit two's complement, wrap gives the offsets for free
        saw_v = {1'b0, r_s1_u[31:15]};
        if (r_s1_u[31]) begin
            saw_v = saw_v - WAVE_W'(131072);
        end
        tri_v = r_s1_u[31:14];                       // last quarter: v - 2^18 == v
        if (r_s1_u[31:30] == 2'b01 || r_s1_u[31:30] == 2'b10) begin
            tri_v = WAVE_W'(131072) - tri_v;
        end

        case (r_wave)
            WAVE_SAW:      w_calc = saw_v;
            WAVE_TRIANGLE: w_calc = tri_v;
            WAVE_SQUARE:   w_calc = (r_s1_u >= {r_duty, 16'd0}) ? WAVE_W'(-65536)
                                                                : WAVE_W'(65536);
            default:       w_calc = '0;              // sine comes from the ROM; stubs are 0
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 2: ROM read registered alongside the computed wave
    // ------------------------------------------------------------------
    logic [SIN_W-1:0]   rom_data;
    logic               r_s2_neg;
    logic               r_s2_is_sine;
    logic [WAVE_W-1:0]  r_s2_w;
    logic [15:0]        r_s2_amp;

    swsyn_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (en2),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en2) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_neg     <= r_s1_u[31];
            r_s2_is_sine <= (r_wave == WAVE_SINE);
            r_s2_w       <= w_calc;
            r_s2_amp     <= r_s1_amp;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: gain, round half up, saturate
    // ------------------------------------------------------------------
    logic signed [WAVE_W-1:0]   w_fin;
    logic signed [PW-1:0]       prod;
    logic signed [RW-1:0]       rnd;
    logic signed [RW-1:0]       shr;
    logic [SAMPLE_BITS-1:0]     n_sample;
    logic [SAMPLE_BITS-1:0]     r_s3_sample;

    always_comb begin
        if (r_s2_is_sine) begin
            w_fin = r_s2_neg ? -$signed(WAVE_W'(rom_data)) : $signed(WAVE_W'(rom_data));
        end else begin
            w_fin = $signed(r_s2_w);
        end
        prod = PW'(w_fin) * $signed({1'b0, r_s2_amp});
        rnd  = RW'(prod) + RND_BIAS;
        shr  = rnd >>> SHIFT;
        if (shr > SMP_HI) begin
            n_sample = SAMPLE_BITS'(SMP_HI);
        end else if (shr < SMP_LO) begin
            n_sample = SAMPLE_BITS'(SMP_LO);
        end else begin
            n_sample = SAMPLE_BITS'(shr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en3) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_sample <= n_sample;
        end
    end

    assign o_m_axis_tvalid = r_s3_v;
    assign o_m_axis_tdata  = OUT_W'(r_s3_sample);

`ifndef ASSERT_OFF
    // back-pressure reaches the input only with every stage full
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_s1_v && r_s2_v && r_s3_v))
        else $error("input stalled with a bubble in the pipeline");

    // oscillator state moves only on an accepted request
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !s_acc) |=> (r_phase == $past(r_phase)) && (r_inc == $past(r_inc)))
        else $error("oscillator state changed without a request");

    // without restart the phase advances by the held increment
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s_acc && !i_s_axis_tuser)
            |=> r_phase == PHASE_BITS'($past(r_phase) + $past(r_inc)))
        else $error("phase step mismatch");

    // with sweep off the increment is kept, or reloaded on restart
    a_inc_no_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s_acc && !r_sweep_en)
            |=> r_inc == ($past(i_s_axis_tuser) ? $past(base_ph) : $past(r_inc)))
        else $error("increment changed with sweep off");
`endif

endmodule

`default_nettype wire

// ===== src/swsyn_sine_rom.sv =====
// Quarter-wave sine ROM, built at elaboration, with a registered read port.
// Depends on swsyn_pkg.
`default_nettype none

module swsyn_sine_rom #(
    parameter int SINE_TABLE_DEPTH = swsyn_pkg::DEF_SINE_DEPTH
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]  i_addr,
    output logic [swsyn_pkg::SIN_W-1:0]                 o_data
);
    import swsyn_pkg::*;

    typedef logic [SIN_W-1:0] t_rom [SINE_TABLE_DEPTH+1];

    // Entry k = round(65536 * sin(pi/2 * k / depth)), Taylor series in Q30
    function automatic t_rom build_rom();
        t_rom                tab;
        logic [63:0]         a;
        logic [63:0]         a2;
        logic [63:0]         term;
        logic signed [63:0]  sum;
        logic signed [63:0]  r;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            a    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
            a2   = (a * a) >> 30;
            term = a;
            sum  = $signed(a);
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                term = ((term * a2) >> 30) / SINE_DIV[n-1];
                if (n[0]) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + 64'sd8192) >>> 14;
            if (r > 64'sd65536) begin
                r = 64'sd65536;
            end
            tab[k] = SIN_W'(r);
        end
        return tab;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [SIN_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SINE_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire
